// ===== design/srhm_pkg.sv =====
// Package with shared types and constants of the sparse register hash map.
`timescale 1ns / 1ps
package srhm_pkg;
  localparam int MaxLgSize = 10;
  localparam int Depth = 1 << MaxLgSize;
  localparam int AddrW = MaxLgSize;
  localparam int KeyW = 21;
  localparam int ValW = 6;
  localparam int CntW = 11;
  localparam int EntryW = KeyW + ValW;

  localparam logic [1:0] ActAdd = 2'd0;
  localparam logic [1:0] ActFind = 2'd1;
  localparam logic [1:0] ActReplace = 2'd2;
  localparam logic [1:0] ActClear = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StDup = 2'd1;
  localparam logic [1:0] StMissing = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  localparam logic [1:0] RegKeyBits = 2'd0;
  localparam logic [1:0] RegInitLg = 2'd1;
  localparam logic [1:0] RegNum = 2'd2;
  localparam logic [1:0] RegDen = 2'd3;

  // One table entry: valid flag, value, key.
  typedef struct packed {
    logic            valid;
    logic [ValW-1:0] value;
    logic [KeyW-1:0] key;
  } entry_t;

  // Memory port request from the sequencer.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    entry_t           wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  // Step of a probe: next position modulo the current size.
  function automatic logic [AddrW-1:0] step_pos(input logic [AddrW-1:0] pos,
                                                input logic [AddrW-1:0] stride,
                                                input logic [AddrW-1:0] mask);
    logic [AddrW-1:0] s;
    begin
      s = pos + stride;
      return s & mask;
    end
  endfunction
endpackage

// ===== design/srhm_store.sv =====
// Table memory of the hash map, with a second bank for rehashing.
`timescale 1ns / 1ps
module srhm_store (
  input  logic                 clk,
  input  logic                 bank,
  input  srhm_pkg::mem_req_t   req,
  input  logic                 other_we,
  input  logic [srhm_pkg::AddrW-1:0] other_addr,
  input  srhm_pkg::entry_t     other_wdata,
  output srhm_pkg::entry_t     rdata,
  output srhm_pkg::entry_t     other_rdata
);
  // Two banks; "bank" selects the live one, the other is the rehash target/source.
  srhm_pkg::entry_t mem0 [srhm_pkg::Depth];
  srhm_pkg::entry_t mem1 [srhm_pkg::Depth];
  srhm_pkg::entry_t rd0;
  srhm_pkg::entry_t rd1;

  always_ff @(posedge clk) begin
    if (bank ? other_we : req.we) begin
      mem0[bank ? other_addr : req.waddr] <= bank ? other_wdata : req.wdata;
    end
    rd0 <= mem0[bank ? other_addr : req.raddr];
  end

  always_ff @(posedge clk) begin
    if (bank ? req.we : other_we) begin
      mem1[bank ? req.waddr : other_addr] <= bank ? req.wdata : other_wdata;
    end
    rd1 <= mem1[bank ? req.raddr : other_addr];
  end

  assign rdata = bank ? rd1 : rd0;
  assign other_rdata = bank ? rd0 : rd1;
endmodule

// ===== design/sparse_register_hash_map.sv =====
// Top level of the sparse register hash map: sequencer, registers and memory.
`timescale 1ns / 1ps
// Add, find and replace answer when their probe ends; clear answers and then sweeps all
// 1024 entries. An add that passes the load limit first clears the other bank, then reads
// each old slot and places it by probing in the new table, and answers when that ends.
// Requests are taken one at a time, only while busy is low.
// Reset: synchronous; a clearing pass of all 1024 entries follows with busy high. The receiver
// cannot stall: each answer shows for one cycle on done.
module sparse_register_hash_map (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [20:0] slot,
  input  logic [5:0]  new_value,
  output logic        done,
  output logic [1:0]  status,
  output logic [5:0]  found_value,
  output logic [10:0] entry_count,
  output logic [3:0]  size_log,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int AW = srhm_pkg::AddrW;

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_RD   = 9'b000000100,
    S_CHK  = 9'b000001000,
    S_GCLR = 9'b000010000,
    S_GRD  = 9'b000100000,
    S_GCHK = 9'b001000000,
    S_PRD  = 9'b010000000,
    S_PCHK = 9'b100000000
  } state_t;

  state_t state;
  logic [4:0] key_bits;
  logic [3:0] init_lg;
  logic [3:0] lnum;
  logic [3:0] lden;
  logic [1:0] act;
  logic [20:0] key;
  logic [5:0] val;
  logic [AW-1:0] pos;
  logic [AW-1:0] first;
  logic [AW-1:0] stride;
  logic [AW-1:0] sweep;
  logic [10:0] occ;
  logic [3:0] lg;
  logic bank;
  logic [AW-1:0] gpos;
  logic [AW-1:0] gfirst;
  logic [AW-1:0] gstride;
  srhm_pkg::entry_t gent;
  logic [1:0] res_st;
  logic [5:0] res_val;
  logic req_done;
  logic done_g;

  srhm_pkg::mem_req_t req;
  logic other_we;
  logic [AW-1:0] other_addr;
  srhm_pkg::entry_t other_wdata;
  srhm_pkg::entry_t rdata;
  srhm_pkg::entry_t other_rdata;

  srhm_store u_store (
    .clk, .bank, .req, .other_we, .other_addr, .other_wdata, .rdata, .other_rdata
  );

  // Derived quantities.
  logic [4:0] kb_eff;
  logic [20:0] kmask;
  logic [AW-1:0] smask;
  logic [AW-1:0] nmask;
  logic [3:0] start_lg;
  logic [20:0] in_key;
  logic [20:0] gkey;
  logic [20:0] tmp_s;
  logic [20:0] tmp_g;
  logic [14:0] lhs;
  logic [14:0] rhs;
  logic [10:0] occ_inc;
  logic [AW-1:0] step_next;
  logic sweep_last;
  state_t grow_adv;
  logic grow_end;
  logic chk_hit;
  logic grow_go;
  logic chk_end;

  assign kb_eff = (key_bits > 5'd21) ? 5'd21 : key_bits;
  assign kmask = 21'((22'd1 << kb_eff) - 22'd1);
  assign smask = AW'((11'd1 << lg) - 11'd1);
  assign nmask = AW'((11'd1 << (lg + 4'd1)) - 11'd1);
  assign start_lg = (init_lg > 4'(srhm_pkg::MaxLgSize)) ? 4'(srhm_pkg::MaxLgSize) : init_lg;
  assign in_key = slot & kmask;
  assign tmp_s = in_key >> lg;
  assign gkey = other_rdata.key & kmask;
  assign tmp_g = gkey >> (lg + 4'd1);
  assign occ_inc = occ + 11'd1;
  // Load test: den*(count+1) versus num*size; size shifted by lg.
  assign lhs = 15'(lden * occ_inc);
  assign rhs = 15'({11'd0, lnum} << lg);

  assign step_next = srhm_pkg::step_pos(pos, stride, smask);
  // Old table has 2^lg entries while growing.
  assign sweep_last = (sweep[AW-1:0] == smask);
  always_comb begin
    grow_adv = sweep_last ? S_IDLE : S_GRD;
  end

  // Probe decisions on the entry read for the current position.
  assign chk_hit = rdata.valid && ((rdata.key & kmask) == key);
  assign grow_go = !rdata.valid && (act == srhm_pkg::ActAdd) &&
                   (lg < 4'(srhm_pkg::MaxLgSize)) && (lhs > rhs);
  assign chk_end = (state == S_CHK) && !grow_go &&
                   (!rdata.valid || chk_hit || step_next == first);

  // A finished growth sends the pending add's result.
  assign grow_end = (state == S_GCHK && !other_rdata.valid && sweep_last) ||
                    (state == S_PCHK && sweep_last &&
                     (!rdata.valid || srhm_pkg::step_pos(gpos, gstride, nmask) == gfirst));

  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      srhm_pkg::RegKeyBits: prdata = {27'd0, key_bits};
      srhm_pkg::RegInitLg:  prdata = {28'd0, init_lg};
      srhm_pkg::RegNum:     prdata = {28'd0, lnum};
      srhm_pkg::RegDen:     prdata = {28'd0, lden};
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bits <= 5'd12;
      init_lg <= 4'd3;
      lnum <= 4'd3;
      lden <= 4'd4;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        srhm_pkg::RegKeyBits: key_bits <= pwdata[4:0];
        srhm_pkg::RegInitLg:  init_lg <= pwdata[3:0];
        srhm_pkg::RegNum:     lnum <= pwdata[3:0];
        srhm_pkg::RegDen:     lden <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Memory request decode.
  always_comb begin
    req = '0;
    other_we = 1'b0;
    other_addr = gpos;
    other_wdata = gent;
    req.raddr = pos;
    case (state)
      S_CLR: begin
        req.we = 1'b1;
        req.waddr = sweep[AW-1:0];
      end
      S_CHK: begin
        if (!rdata.valid && act == srhm_pkg::ActAdd) begin
          req.we = 1'b1;
          req.waddr = pos;
          req.wdata = '{valid: 1'b1, value: val, key: key};
        end else if (chk_hit && act == srhm_pkg::ActReplace) begin
          // A replace also stores the key under the current mask.
          req.we = 1'b1;
          req.waddr = pos;
          req.wdata = '{valid: 1'b1, value: val, key: key};
        end
      end
      S_GCLR: begin
        // Clear the target bank (the other one) before refilling.
        other_we = 1'b1;
        other_addr = sweep[AW-1:0];
        other_wdata = '0;
      end
      S_GRD, S_GCHK: begin
        other_addr = sweep[AW-1:0];
      end
      S_PRD: begin
        req.raddr = gpos;
      end
      S_PCHK: begin
        if (!rdata.valid) begin
          req.we = 1'b1;
          req.waddr = gpos;
          req.wdata = gent;
        end
        req.raddr = gpos;
      end
      default: ;
    endcase
  end

  // During growth the live bank is the new one: bank is flipped at GCLR end.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      sweep <= '0;
      occ <= '0;
      lg <= 4'd3;
      bank <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          sweep <= sweep + 1'b1;
          if (sweep[AW-1:0] == {AW{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            act <= action;
            key <= in_key;
            val <= new_value;
            if (action == srhm_pkg::ActClear) begin
              sweep <= '0;
              occ <= '0;
              lg <= start_lg;
              state <= S_CLR;
              res_st <= srhm_pkg::StOk;
              res_val <= '0;
            end else begin
              pos <= in_key[AW-1:0] & smask;
              first <= in_key[AW-1:0] & smask;
              stride <= (tmp_s[AW-1:0] | AW'(1)) & smask;
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (!rdata.valid) begin
            res_val <= '0;
            if (act == srhm_pkg::ActAdd) begin
              occ <= occ_inc;
              res_st <= srhm_pkg::StOk;
              if (grow_go) begin
                sweep <= '0;
                state <= S_GCLR;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              res_st <= srhm_pkg::StMissing;
              state <= S_IDLE;
            end
          end else if (chk_hit) begin
            state <= S_IDLE;
            case (act)
              srhm_pkg::ActAdd: begin
                res_st <= srhm_pkg::StDup;
                res_val <= '0;
              end
              srhm_pkg::ActFind: begin
                res_st <= srhm_pkg::StOk;
                res_val <= rdata.value;
              end
              default: begin
                res_st <= srhm_pkg::StOk;
                res_val <= '0;
              end
            endcase
          end else if (step_next == first) begin
            res_st <= srhm_pkg::StFull;
            res_val <= '0;
            state <= S_IDLE;
          end else begin
            pos <= step_next;
            state <= S_RD;
          end
        end
        S_GCLR: begin
          sweep <= sweep + 1'b1;
          if (sweep[AW-1:0] == {AW{1'b1}}) begin
            bank <= ~bank;
            state <= S_GRD;
          end
        end
        S_GRD: state <= S_GCHK;
        S_GCHK: begin
          if (other_rdata.valid) begin
            gent <= other_rdata;
            gpos <= gkey[AW-1:0] & nmask;
            gfirst <= gkey[AW-1:0] & nmask;
            gstride <= (tmp_g[AW-1:0] | AW'(1)) & nmask;
            state <= S_PRD;
          end else begin
            state <= grow_adv;
          end
          if (!other_rdata.valid) sweep <= sweep + 1'b1;
          if (!other_rdata.valid && sweep_last) lg <= lg + 4'd1;
        end
        S_PRD: state <= S_PCHK;
        S_PCHK: begin
          if (!rdata.valid ||
              srhm_pkg::step_pos(gpos, gstride, nmask) == gfirst) begin
            sweep <= sweep + 1'b1;
            if (sweep_last) lg <= lg + 4'd1;
            state <= grow_adv;
          end else begin
            gpos <= srhm_pkg::step_pos(gpos, gstride, nmask);
            state <= S_PRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Strobe for a clear or for a probe that ends without growth.
  always_ff @(posedge clk) begin
    if (rst) req_done <= 1'b0;
    else req_done <= (state == S_IDLE && start && action == srhm_pkg::ActClear) || chk_end;
  end

  always_ff @(posedge clk) begin
    if (rst) done_g <= 1'b0;
    else done_g <= grow_end;
  end

  assign busy = (state != S_IDLE) || rst;
  always_comb begin
    status = res_st;
    found_value = res_val;
    entry_count = occ;
    size_log = lg;
  end

  // Final strobe merges the normal and growth completions.
  assign done = req_done | done_g;

`ifndef SYNTHESIS
  a_idle_no_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !busy) else $error("busy in idle");
  a_lg_range: assert property (@(posedge clk) disable iff (rst)
    lg <= 4'(srhm_pkg::MaxLgSize)) else $error("size above max");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action != srhm_pkg::ActClear) |=> busy) else $error("no probe");
`endif
endmodule
